@@ hw/rtl/lodx_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lodx_pkg
// Shared widths, register indexes and the configuration bundle of the
// level-of-detail selector.
// ----------------------------------------------------------------------------
package lodx_pkg;

  localparam int LVL_W      = 2;
  localparam int THR_W      = 18;
  localparam int SCALE_W    = 10;
  localparam int RATE_W     = 12;
  localparam int FTIME_W    = 16;
  localparam int FADE_W     = 17;
  localparam int DIST_W     = 18;
  localparam int CNT_W      = 3;
  localparam int NUM_THR    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int FRAC_SHIFT = 8;

  localparam logic [FADE_W-1:0] FADE_ONE = 17'd65536;
  localparam logic [DIST_W-1:0] DIST_MAX = 18'd262143;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_COUNT = 3'd0,
    REG_THR0        = 3'd1,
    REG_THR1        = 3'd2,
    REG_THR2        = 3'd3,
    REG_THR3        = 3'd4,
    REG_SCALE       = 3'd5,
    REG_FADE_RATE   = 3'd6,
    REG_CROSSFADE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]                level_count;
    logic [NUM_THR-1:0][THR_W-1:0]   thr;
    logic [SCALE_W-1:0]              scale;
    logic [RATE_W-1:0]               rate;
    logic                            crossfade_on;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    level_count:  3'd0,
    thr:          '0,
    scale:        10'd256,
    rate:         12'd512,
    crossfade_on: 1'b1
  };

endpackage
`default_nettype wire

@@ hw/rtl/lodx_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lodx_cfg
// Configuration register file; one register is written per beat.
// ----------------------------------------------------------------------------
module lodx_cfg
  import lodx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_idx))
        REG_LEVEL_COUNT: cfg_nxt.level_count  = wr_data[CNT_W-1:0];
        REG_THR0:        cfg_nxt.thr[0]       = wr_data[THR_W-1:0];
        REG_THR1:        cfg_nxt.thr[1]       = wr_data[THR_W-1:0];
        REG_THR2:        cfg_nxt.thr[2]       = wr_data[THR_W-1:0];
        REG_THR3:        cfg_nxt.thr[3]       = wr_data[THR_W-1:0];
        REG_SCALE:       cfg_nxt.scale        = wr_data[SCALE_W-1:0];
        REG_FADE_RATE:   cfg_nxt.rate         = wr_data[RATE_W-1:0];
        REG_CROSSFADE:   cfg_nxt.crossfade_on = wr_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ hw/rtl/lodx_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lodx_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lodx_mul #(
  parameter int W = 17
) (
  input  wire logic           clk,
  input  wire logic [W-1:0]   op_a,
  input  wire logic [W-1:0]   op_b,
  output logic [2*W-1:0]      prod
);

  logic [2*W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

@@ hw/rtl/lodx_lvl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lodx_lvl
// Picks the first level whose threshold exceeds the scaled distance.
// ----------------------------------------------------------------------------
module lodx_lvl
  import lodx_pkg::*;
#(
  parameter int LEVELS = 4,
  parameter int SC_W   = 27
) (
  input  wire cfg_t               cfg,
  input  wire logic [SC_W-1:0]    scaled,
  output logic [LVL_W-1:0]        level
);

  localparam int CMP_W = (SC_W > THR_W + FRAC_SHIFT) ? SC_W : THR_W + FRAC_SHIFT;

  logic [CNT_W-1:0] n_used;

  always_comb begin
    n_used = (cfg.level_count > CNT_W'(LEVELS)) ? CNT_W'(LEVELS) : cfg.level_count;
    level  = (n_used == '0) ? '0 : LVL_W'(n_used - CNT_W'(1));
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < n_used) &&
          (CMP_W'(scaled) < CMP_W'({cfg.thr[i], {FRAC_SHIFT{1'b0}}}))) begin
        level = LVL_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/lod_select_with_crossfade.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lod_select_with_crossfade
// Distance-based level-of-detail selection with a timed crossfade.
//
//   Port group | Direction | Handshake       | Beat contents
//   in_*       | input     | valid / stall   | object and camera position, frame time
//   out_*      | output    | valid / stall   | distance, levels, fade amount, fading
//   cfg_*      | input     | valid / ready   | register index and write data
//
// Each item is worked through before the next is taken: the coordinate
// differences are squared and summed on the shared multiplier, then come
// COORD_BITS + 1 square root steps, the scale multiply, the level pick
// and the fade update. The input is stalled while an item is in flight.
// Reset is synchronous and clears the level and fade state and restores the
// configuration defaults. A finished result waits in the output register
// while the next beat is accepted.
// ----------------------------------------------------------------------------
module lod_select_with_crossfade
  import lodx_pkg::*;
#(
  parameter int LEVELS     = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,

  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_object_x,
  input  wire logic signed [COORD_BITS-1:0] in_object_y,
  input  wire logic signed [COORD_BITS-1:0] in_object_z,
  input  wire logic signed [COORD_BITS-1:0] in_camera_x,
  input  wire logic signed [COORD_BITS-1:0] in_camera_y,
  input  wire logic signed [COORD_BITS-1:0] in_camera_z,
  input  wire logic [FTIME_W-1:0]           in_frame_time,

  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [DIST_W-1:0]                 out_distance,
  output logic [LVL_W-1:0]                  out_active_level,
  output logic [LVL_W-1:0]                  out_prior_level,
  output logic [FADE_W-1:0]                 out_fade_amount,
  output logic                              out_fading,

  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int ROOT_W  = COORD_BITS + 1;
  localparam int SUM_W   = 2 * COORD_BITS + 2;
  localparam int REM_W   = COORD_BITS + 3;
  localparam int MUL_W   = (ROOT_W > FTIME_W) ? ROOT_W : FTIME_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SC_W    = ROOT_W + SCALE_W;
  localparam int STEP_W  = $clog2(ROOT_W + 1);
  localparam int INC_W   = FTIME_W + RATE_W - FRAC_SHIFT;
  localparam int ACC_W   = INC_W + 1;
  localparam int DCMP_W  = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ROOT   = 6'b000100,
    ST_SCALE  = 6'b001000,
    ST_LEVEL  = 6'b010000,
    ST_FADE   = 6'b100000
  } state_t;

  cfg_t                     cfg;
  logic                     in_acc;
  logic                     out_free;
  logic signed [ROOT_W-1:0] dif [3];
  logic [ROOT_W-1:0]        mag_in [3];
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [PROD_W-1:0]        prod;
  logic [LVL_W-1:0]         lvl_pick;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         trial;
  logic                     root_ge;
  logic [INC_W-1:0]         fade_inc;
  logic [ACC_W-1:0]         fade_acc;
  logic [DCMP_W-1:0]        root_ext;

  state_t              state_r,    state_nxt;
  logic [STEP_W-1:0]   cnt_r,      cnt_nxt;
  logic [ROOT_W-1:0]   mag_r [3];
  logic [ROOT_W-1:0]   mag_nxt [3];
  logic [FTIME_W-1:0]  ftime_r,    ftime_nxt;
  logic [SUM_W-1:0]    sum_r,      sum_nxt;
  logic [REM_W-1:0]    rem_r,      rem_nxt;
  logic [ROOT_W-1:0]   root_r,     root_nxt;
  logic [LVL_W-1:0]    cur_lvl_r,  cur_lvl_nxt;
  logic [LVL_W-1:0]    prev_lvl_r, prev_lvl_nxt;
  logic [FADE_W-1:0]   prog_r,     prog_nxt;
  logic                active_r,   active_nxt;
  logic                ovalid_r,   ovalid_nxt;
  logic [DIST_W-1:0]   odist_r,    odist_nxt;
  logic [LVL_W-1:0]    oact_r,     oact_nxt;
  logic [LVL_W-1:0]    oprior_r,   oprior_nxt;
  logic [FADE_W-1:0]   ofade_r,    ofade_nxt;
  logic                ofading_r,  ofading_nxt;

  lodx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  lodx_mul #(.W(MUL_W)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  lodx_lvl #(.LEVELS(LEVELS), .SC_W(SC_W)) u_lvl (
    .cfg    (cfg),
    .scaled (prod[SC_W-1:0]),
    .level  (lvl_pick)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !ovalid_r || !out_stall;

  assign dif[0] = ROOT_W'(in_object_x) - ROOT_W'(in_camera_x);
  assign dif[1] = ROOT_W'(in_object_y) - ROOT_W'(in_camera_y);
  assign dif[2] = ROOT_W'(in_object_z) - ROOT_W'(in_camera_z);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = dif[i][ROOT_W-1] ? ROOT_W'(-dif[i]) : ROOT_W'(dif[i]);
    end
  end

  always_comb begin
    case (state_r)
      ST_SQUARE: begin
        case (cnt_r[1:0])
          2'd0:    mul_a = MUL_W'(mag_r[0]);
          2'd1:    mul_a = MUL_W'(mag_r[1]);
          2'd2:    mul_a = MUL_W'(mag_r[2]);
          default: mul_a = '0;
        endcase
        mul_b = mul_a;
      end
      ST_SCALE: begin
        mul_a = MUL_W'(root_r);
        mul_b = MUL_W'(cfg.scale);
      end
      ST_LEVEL, ST_FADE: begin
        mul_a = MUL_W'(ftime_r);
        mul_b = MUL_W'(cfg.rate);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rem_sh   = {rem_r[REM_W-3:0], sum_r[SUM_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign root_ge  = (rem_sh >= trial);
  assign fade_inc = prod[FTIME_W+RATE_W-1:FRAC_SHIFT];
  assign fade_acc = ACC_W'(prog_r) + ACC_W'(fade_inc);
  assign root_ext = DCMP_W'(root_r);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    mag_nxt      = mag_r;
    ftime_nxt    = ftime_r;
    sum_nxt      = sum_r;
    rem_nxt      = rem_r;
    root_nxt     = root_r;
    cur_lvl_nxt  = cur_lvl_r;
    prev_lvl_nxt = prev_lvl_r;
    prog_nxt     = prog_r;
    active_nxt   = active_r;
    ovalid_nxt   = ovalid_r && out_stall;
    odist_nxt    = odist_r;
    oact_nxt     = oact_r;
    oprior_nxt   = oprior_r;
    ofade_nxt    = ofade_r;
    ofading_nxt  = ofading_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mag_nxt   = mag_in;
          ftime_nxt = in_frame_time;
          cnt_nxt   = '0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (cnt_r == '0) begin
          sum_nxt = '0;
        end else begin
          sum_nxt = sum_r + prod[SUM_W-1:0];
        end
        if (cnt_r == STEP_W'(3)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_ROOT: begin
        rem_nxt  = root_ge ? rem_sh - trial : rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], root_ge};
        sum_nxt  = {sum_r[SUM_W-3:0], 2'b00};
        if (cnt_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = ST_SCALE;
        end else begin
          cnt_nxt = cnt_r + STEP_W'(1);
        end
      end
      ST_SCALE: begin
        state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        if (lvl_pick != cur_lvl_r) begin
          if (cfg.crossfade_on) begin
            active_nxt   = 1'b1;
            prog_nxt     = '0;
            prev_lvl_nxt = cur_lvl_r;
          end
          cur_lvl_nxt = lvl_pick;
        end
        state_nxt = ST_FADE;
      end
      ST_FADE: begin
        if (out_free) begin
          if (active_r) begin
            if (fade_acc >= ACC_W'(FADE_ONE)) begin
              prog_nxt   = FADE_ONE;
              active_nxt = 1'b0;
            end else begin
              prog_nxt = fade_acc[FADE_W-1:0];
            end
          end
          ovalid_nxt  = 1'b1;
          odist_nxt   = (root_ext > DCMP_W'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];
          oact_nxt    = cur_lvl_r;
          oprior_nxt  = prev_lvl_r;
          ofade_nxt   = prog_nxt;
          ofading_nxt = active_nxt;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      cur_lvl_r  <= '0;
      prev_lvl_r <= '0;
      prog_r     <= '0;
      active_r   <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      cur_lvl_r  <= cur_lvl_nxt;
      prev_lvl_r <= prev_lvl_nxt;
      prog_r     <= prog_nxt;
      active_r   <= active_nxt;
      ovalid_r   <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    ftime_r   <= ftime_nxt;
    sum_r     <= sum_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    odist_r   <= odist_nxt;
    oact_r    <= oact_nxt;
    oprior_r  <= oprior_nxt;
    ofade_r   <= ofade_nxt;
    ofading_r <= ofading_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_distance     = odist_r;
  assign out_active_level = oact_r;
  assign out_prior_level  = oprior_r;
  assign out_fade_amount  = ofade_r;
  assign out_fading       = ofading_r;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall
  ) else $error("input not stalled after an accepted beat");

  a_fading_below_one: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && out_fading |-> (out_fade_amount < FADE_ONE)
  ) else $error("fade reported in progress at full amount");

  a_result_frees_input: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall
  ) else $error("new result without the sequencer returning to idle");

endmodule
`default_nettype wire

@@ tb/lod_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lod_checker
// Watches the input, result and register channels of the level-of-detail
// selector. It keeps its own copy of the registers and of the level and fade
// state, works out the result of every accepted input beat, and compares
// each accepted result beat field by field with the oldest result still due.
// ----------------------------------------------------------------------------
module lod_checker
  import lodx_pkg::*;
#(
  parameter int COORD_W = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic signed [COORD_W-1:0] in_object_x,
  input  wire logic signed [COORD_W-1:0] in_object_y,
  input  wire logic signed [COORD_W-1:0] in_object_z,
  input  wire logic signed [COORD_W-1:0] in_camera_x,
  input  wire logic signed [COORD_W-1:0] in_camera_y,
  input  wire logic signed [COORD_W-1:0] in_camera_z,
  input  wire logic [FTIME_W-1:0]        in_frame_time,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic [DIST_W-1:0]         out_distance,
  input  wire logic [LVL_W-1:0]          out_active_level,
  input  wire logic [LVL_W-1:0]          out_prior_level,
  input  wire logic [FADE_W-1:0]         out_fade_amount,
  input  wire logic                      out_fading,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data,
  output int                             mismatch_count,
  output int                             results_owed
);

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [LVL_W-1:0]  active_level;
    logic [LVL_W-1:0]  prior_level;
    logic [FADE_W-1:0] fade_amount;
    logic              fading;
  } lod_result_t;

  lod_result_t       lod_results_due[$];
  cfg_t              setup;
  logic [LVL_W-1:0]  cur_level;
  logic [LVL_W-1:0]  prev_level;
  logic [FADE_W-1:0] fade_prog;
  logic              fade_busy;

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic longint unsigned squared_gap(logic signed [COORD_W-1:0] a,
                                                  logic signed [COORD_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return longint'(d * d);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = n;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic logic [LVL_W-1:0] level_for(longint unsigned measured);
    longint unsigned scaled;
    int              n;
    scaled = measured * longint'(setup.scale);
    n      = int'(setup.level_count);
    if (n == 0) return '0;
    if (n > NUM_THR) n = NUM_THR;
    for (int i = 0; i < n; i++) begin
      if (scaled < (longint'(setup.thr[i]) << FRAC_SHIFT)) return LVL_W'(i);
    end
    return LVL_W'(n - 1);
  endfunction

  task automatic advance_lod_state();
    longint unsigned sum;
    longint unsigned measured;
    longint unsigned acc;
    logic [LVL_W-1:0] next;
    lod_result_t      res;
    sum  = squared_gap(in_object_x, in_camera_x) + squared_gap(in_object_y, in_camera_y) +
           squared_gap(in_object_z, in_camera_z);
    measured = floor_root(sum);
    next = level_for(measured);
    if (next != cur_level) begin
      if (setup.crossfade_on) begin
        fade_busy  = 1'b1;
        fade_prog  = '0;
        prev_level = cur_level;
      end
      cur_level = next;
    end
    if (fade_busy) begin
      acc = longint'(fade_prog) +
            ((longint'(in_frame_time) * longint'(setup.rate)) >> FRAC_SHIFT);
      if (acc >= longint'(FADE_ONE)) begin
        acc       = longint'(FADE_ONE);
        fade_busy = 1'b0;
      end
      fade_prog = FADE_W'(acc);
    end
    res.distance     = (measured > longint'(DIST_MAX)) ? DIST_MAX : DIST_W'(measured);
    res.active_level = cur_level;
    res.prior_level  = prev_level;
    res.fade_amount  = fade_prog;
    res.fading       = fade_busy;
    lod_results_due  = {lod_results_due, res};
  endtask

  always @(posedge clk) begin
    lod_result_t want;
    if (!rst_n) begin
      setup      = CFG_RESET;
      cur_level  = '0;
      prev_level = '0;
      fade_prog  = '0;
      fade_busy  = 1'b0;
      lod_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (lod_results_due.size() == 0) begin
          report_mismatch("result beat with nothing due, distance", out_distance, 0);
        end else begin
          want = lod_results_due.pop_front();
          if (out_distance !== want.distance)
            report_mismatch("distance", out_distance, want.distance);
          if (out_active_level !== want.active_level)
            report_mismatch("active_level", out_active_level, want.active_level);
          if (out_prior_level !== want.prior_level)
            report_mismatch("prior_level", out_prior_level, want.prior_level);
          if (out_fade_amount !== want.fade_amount)
            report_mismatch("fade_amount", out_fade_amount, want.fade_amount);
          if (out_fading !== want.fading)
            report_mismatch("fading", out_fading, want.fading);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_LEVEL_COUNT: setup.level_count = cfg_data[CNT_W-1:0];
          REG_THR0: setup.thr[0] = cfg_data[THR_W-1:0];
          REG_THR1: setup.thr[1] = cfg_data[THR_W-1:0];
          REG_THR2: setup.thr[2] = cfg_data[THR_W-1:0];
          REG_THR3: setup.thr[3] = cfg_data[THR_W-1:0];
          REG_SCALE: setup.scale = cfg_data[SCALE_W-1:0];
          REG_FADE_RATE: setup.rate = cfg_data[RATE_W-1:0];
          REG_CROSSFADE: setup.crossfade_on = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_lod_state();
    end
    results_owed <= lod_results_due.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the level-of-detail selector with a directed set of positions and
// register settings, then with random phases of settings and positions under
// random idling on both channels and one long result hold-off. A checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import lodx_pkg::*;

  localparam int COORD_W         = 16;
  localparam int CYCLE_LIMIT     = 700000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 136;
  localparam int LONG_HOLD       = 400;
  localparam int MAX_IDLE        = 14;

  logic                      clk           = 1'b0;
  logic                      rst_n         = 1'b0;
  logic                      in_valid      = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_object_x   = '0;
  logic signed [COORD_W-1:0] in_object_y   = '0;
  logic signed [COORD_W-1:0] in_object_z   = '0;
  logic signed [COORD_W-1:0] in_camera_x   = '0;
  logic signed [COORD_W-1:0] in_camera_y   = '0;
  logic signed [COORD_W-1:0] in_camera_z   = '0;
  logic [FTIME_W-1:0]        in_frame_time = '0;
  logic                      out_valid;
  logic                      out_stall     = 1'b0;
  logic [DIST_W-1:0]         out_distance;
  logic [LVL_W-1:0]          out_active_level;
  logic [LVL_W-1:0]          out_prior_level;
  logic [FADE_W-1:0]         out_fade_amount;
  logic                      out_fading;
  logic                      cfg_valid     = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index     = '0;
  logic [CFG_DATA_W-1:0]     cfg_data      = '0;

  int mismatch_count;
  int results_owed;
  int cycle_count;
  bit quiet        = 1'b0;
  bit hold_request = 1'b0;

  always #6 clk = ~clk;

  lod_select_with_crossfade #(
    .COORD_BITS(COORD_W)
  ) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_object_x(in_object_x), .in_object_y(in_object_y), .in_object_z(in_object_z),
    .in_camera_x(in_camera_x), .in_camera_y(in_camera_y), .in_camera_z(in_camera_z),
    .in_frame_time(in_frame_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_active_level(out_active_level),
    .out_prior_level(out_prior_level), .out_fade_amount(out_fade_amount),
    .out_fading(out_fading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lod_checker #(
    .COORD_W(COORD_W)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_object_x(in_object_x), .in_object_y(in_object_y), .in_object_z(in_object_z),
    .in_camera_x(in_camera_x), .in_camera_y(in_camera_y), .in_camera_z(in_camera_z),
    .in_frame_time(in_frame_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distance(out_distance), .out_active_level(out_active_level),
    .out_prior_level(out_prior_level), .out_fade_amount(out_fade_amount),
    .out_fading(out_fading),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  task automatic drain();
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_setup(int unsigned lvl, int unsigned t0, int unsigned t1,
                             int unsigned t2, int unsigned t3, int unsigned scale,
                             int unsigned rate, int unsigned xfade);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_LEVEL_COUNT, lvl);
    write_reg(REG_THR0, t0);
    write_reg(REG_THR1, t1);
    write_reg(REG_THR2, t2);
    write_reg(REG_THR3, t3);
    write_reg(REG_SCALE, scale);
    write_reg(REG_FADE_RATE, rate);
    write_reg(REG_CROSSFADE, xfade);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_position(int ox, int oy, int oz, int cx, int cy, int cz, int ft);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_object_x   <= ox[COORD_W-1:0];
    in_object_y   <= oy[COORD_W-1:0];
    in_object_z   <= oz[COORD_W-1:0];
    in_camera_x   <= cx[COORD_W-1:0];
    in_camera_y   <= cy[COORD_W-1:0];
    in_camera_z   <= cz[COORD_W-1:0];
    in_frame_time <= ft[FTIME_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_setup(int phase);
    int unsigned lvl;
    int unsigned t[4];
    int unsigned swap;
    int unsigned scale;
    int unsigned rate;
    int unsigned xfade;
    int          e;
    lvl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    e   = $urandom_range(8, 18);
    for (int i = 0; i < 4; i++) t[i] = $urandom_range(0, (1 << e) - 1);
    if ($urandom_range(0, 4) != 0) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3 - i; j++) begin
          if (t[j] > t[j+1]) begin
            swap   = t[j];
            t[j]   = t[j+1];
            t[j+1] = swap;
          end
        end
      end
    end
    scale = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(160, 400);
    rate  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : $urandom_range(64, 1024);
    xfade = ($urandom_range(0, 3) != 0);
    case (phase)
      0: begin
        scale = 0;
        rate  = 0;
      end
      1: begin
        scale = 1023;
        rate  = 4095;
      end
      2: begin
        lvl = 7;
        for (int i = 0; i < 4; i++) t[i] = 262143;
      end
      3: for (int i = 0; i < 4; i++) t[i] = 0;
      4: lvl = 0;
      default: ;
    endcase
    write_setup(lvl, t[0], t[1], t[2], t[3], scale, rate, xfade);
  endtask

  task automatic send_random_position();
    int cam[3];
    int obj[3];
    int amp;
    int ft;
    for (int a = 0; a < 3; a++) cam[a] = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 7) == 0) begin
      for (int a = 0; a < 3; a++) obj[a] = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      amp = 1 << $urandom_range(0, 16);
      for (int a = 0; a < 3; a++) begin
        obj[a] = cam[a] + int'($urandom_range(0, 2 * amp)) - amp;
        if (obj[a] > 32767) obj[a] = 32767;
        if (obj[a] < -32768) obj[a] = -32768;
      end
    end
    case ($urandom_range(0, 4))
      0: ft = $urandom_range(0, 1023);
      1: ft = $urandom_range(0, 8191);
      4: ft = ($urandom_range(0, 1) == 0) ? 0 : 65535;
      default: ft = $urandom_range(0, 65535);
    endcase
    send_position(obj[0], obj[1], obj[2], cam[0], cam[1], cam[2], ft);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lod_select_with_crossfade: mismatch");
    $finish;
  end

  initial begin
    int hold;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold         = LONG_HOLD;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_position(0, 0, 0, 0, 0, 0, 0);
    send_position(32767, 32767, 32767, -32768, -32768, -32768, 65535);

    write_setup(4, 160, 1600, 16000, 160000, 256, 512, 1);
    send_position(0, 0, 0, 0, 0, 0, 1000);
    send_position(159, 0, 0, 0, 0, 0, 4096);
    send_position(160, 0, 0, 0, 0, 0, 4096);
    send_position(0, 0, 0, -160, 0, 0, 4096);
    send_position(0, 1600, 0, 0, 0, 0, 0);
    send_position(0, 1600, 0, 0, 0, 0, 65535);
    send_position(-32768, -32768, -32768, 32767, 32767, 32767, 1);
    send_position(0, -3000, 0, 0, 0, -4000, 30000);
    send_position(32767, 0, 0, -32768, 0, 0, 2000);

    write_setup(4, 160, 1600, 16000, 160000, 256, 512, 0);
    send_position(0, 0, 0, 0, 0, 0, 3000);
    send_position(0, 0, 1600, 0, 0, 0, 2000);

    write_setup(7, 5000, 100, 262143, 0, 1023, 4095, 1);
    send_position(50, 0, 0, 0, 0, 0, 100);
    send_position(0, 0, 0, 0, 6000, 0, 100);
    send_position(-32768, -32768, -32768, 32767, 32767, 32767, 100);
    send_position(-32768, -32768, -32768, 32767, 32767, 32767, 65535);

    write_setup(7, 5000, 100, 262143, 0, 0, 0, 1);
    send_position(32767, 32767, 32767, -32768, -32768, -32768, 65535);
    send_position(0, 0, 0, 0, 0, 0, 65535);

    for (int phase = 0; phase < PHASES; phase++) begin
      random_setup(phase);
      quiet = (phase % 4 == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 5 && n == 20) hold_request = 1'b1;
        send_random_position();
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("lod_select_with_crossfade: match");
    end else begin
      $display("lod_select_with_crossfade: mismatch");
    end
    $finish;
  end

endmodule
